FILE: rtl/core/atma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package atma_pkg;

  // Default averaging window length in samples.
  localparam int unsigned WindowDef = 20;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps = 22;
  localparam logic signed [15:0] AngleHalfPi = 16'sd16384;

  // Arctangent table in binary angle units.
  function automatic logic [13:0] atan_lut(input logic [3:0] idx);
    logic [13:0] v;
    unique case (idx)
      4'd0: v = 14'd8192;
      4'd1: v = 14'd4836;
      4'd2: v = 14'd2555;
      4'd3: v = 14'd1297;
      4'd4: v = 14'd651;
      4'd5: v = 14'd326;
      4'd6: v = 14'd163;
      4'd7: v = 14'd81;
      4'd8: v = 14'd41;
      4'd9: v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      4'd14: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/atma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module atma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/atma_tilt.sv
`timescale 1ns / 1ps
`default_nettype none
module atma_tilt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] vec_x,
  input  wire logic signed [15:0] vec_y,
  input  wire logic signed [15:0] vec_z,
  output logic                    done,
  output logic signed [15:0]      roll,
  output logic signed [15:0]      pitch
);
  import atma_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_SQRT = 5'b00100,
    S_CORD = 5'b01000,
    S_NEXT = 5'b10000
  } tilt_state_t;

  tilt_state_t state_r, state_nxt;
  logic        pass_r;  // 0 roll, 1 pitch
  logic [4:0]  cnt_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic signed [16:0] a_r;
  logic [15:0] root_r;
  logic [31:0] acc_r;
  logic signed [41:0] cx_r, cy_r;
  logic signed [16:0] cz_r;
  logic s_zero_r;

  // Squares of the two components under the root for this pass: x or y, and z.
  logic signed [15:0] h0, h1;
  logic [31:0] sq0, sq1;
  always_comb begin
    h0 = pass_r ? y_r : x_r;
    h1 = z_r;
    sq0 = 32'(h0 * h0);
    sq1 = 32'(h1 * h1);
  end

  // One restoring square root step (two bits of the radicand).
  logic [17:0] part_r;
  logic [17:0] trial;
  logic [17:0] part_nxt;
  logic        ge;
  always_comb begin
    trial    = {root_r, 2'b01};
    part_nxt = {part_r[15:0], acc_r[31:30]};
  end
  assign ge = part_nxt >= trial;

  // One CORDIC rotation step.
  logic [3:0] ci;
  logic signed [41:0] dx, dy, nx, ny;
  logic signed [16:0] nz;
  logic [13:0] tv;
  always_comb begin
    ci = cnt_r[3:0];
    dx = cx_r >>> ci;
    dy = cy_r >>> ci;
    tv = atan_lut(ci);
    if (!cy_r[41]) begin
      nx = cx_r + dy;
      ny = cy_r - dx;
      nz = cz_r + 17'(tv);
    end else begin
      nx = cx_r - dy;
      ny = cy_r + dx;
      nz = cz_r - 17'(tv);
    end
  end

  logic signed [15:0] ang;
  always_comb begin
    if (s_zero_r) begin
      ang = a_r > 0 ? AngleHalfPi : (a_r < 0 ? -AngleHalfPi : 16'sd0);
    end else if (cz_r > 17'(AngleHalfPi)) begin
      ang = AngleHalfPi;
    end else if (cz_r < -17'(AngleHalfPi)) begin
      ang = -AngleHalfPi;
    end else begin
      ang = cz_r[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == 5'(SqrtSteps - 1)) state_nxt = S_CORD;
      S_CORD: if (cnt_r == 5'(CordicSteps - 1)) state_nxt = S_NEXT;
      S_NEXT: state_nxt = pass_r ? S_IDLE : S_SQ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done <= 1'b0;
      pass_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      done <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          pass_r <= 1'b0;
          cnt_r <= '0;
        end
        S_SQ: cnt_r <= '0;
        S_SQRT: cnt_r <= (cnt_r == 5'(SqrtSteps - 1)) ? '0 : cnt_r + 5'd1;
        S_CORD: cnt_r <= cnt_r + 5'd1;
        S_NEXT: begin
          cnt_r <= '0;
          pass_r <= 1'b1;
          done <= pass_r;
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r <= vec_x;
        y_r <= vec_y;
        z_r <= vec_z;
      end
      S_SQ: begin
        acc_r <= sq0 + sq1;
        part_r <= '0;
        root_r <= '0;
        a_r <= pass_r ? -17'(x_r) : 17'(y_r);
      end
      S_SQRT: begin
        acc_r <= {acc_r[29:0], 2'b00};
        if (ge) begin
          part_r <= part_nxt - trial;
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          part_r <= part_nxt;
          root_r <= {root_r[14:0], 1'b0};
        end
        if (cnt_r == 5'(SqrtSteps - 1)) begin
          cx_r <= 42'(ge ? {root_r[14:0], 1'b1} : {root_r[14:0], 1'b0}) <<< 8;
          s_zero_r <= !ge && (root_r[14:0] == '0);
          cy_r <= 42'(a_r) <<< 8;
          cz_r <= '0;
        end
      end
      S_CORD: begin
        cx_r <= nx;
        cy_r <= ny;
        cz_r <= nz;
      end
      S_NEXT: begin
        if (pass_r) pitch <= ang;
        else roll <= ang;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/atma_avg.sv
`timescale 1ns / 1ps
`default_nettype none
module atma_avg #(
  parameter int unsigned Window = atma_pkg::WindowDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               ok,
  input  wire logic signed [15:0] smp_x,
  input  wire logic signed [15:0] smp_y,
  input  wire logic signed [15:0] smp_z,
  output logic                    done,
  output logic signed [15:0]      avg_x,
  output logic signed [15:0]      avg_y,
  output logic signed [15:0]      avg_z
);
  import atma_pkg::*;

  localparam int unsigned SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned Depth = 4 * (1 << SlotW);
  localparam int unsigned AddrW = SlotW + 2;
  localparam int unsigned CntW = $clog2(Window + 1);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_RD   = 6'b000010,
    A_UPD  = 6'b000100,
    A_DIV  = 6'b001000,
    A_STO  = 6'b010000,
    A_FIN  = 6'b100000
  } avg_state_t;

  avg_state_t state_r;
  logic [1:0] ax_r;
  logic [4:0] cnt_r;
  logic ok_r;
  logic [CntW-1:0] fill_r;
  logic [SlotW-1:0] slot_r;
  logic signed [20:0] sum_r [3];
  logic signed [15:0] smp_r [3];
  logic [21:0] quo_r;
  logic [21:0] rem_r;
  logic neg_r;

  // Window samples: axis in the high address bits, slot in the low.
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [15:0] rdata;
  assign raddr = {ax_r, slot_r};
  assign waddr = {ax_r, slot_r};
  assign we = (state_r == A_UPD) && ok_r;

  atma_ram #(.Width(16), .Depth(Depth)) u_win (
    .clk(clk), .we(we), .waddr(waddr), .wdata(smp_r[ax_r]),
    .raddr(raddr), .rdata(rdata)
  );

  logic signed [20:0] new_sum;
  logic full;
  assign full = fill_r == CntW'(Window);
  assign new_sum = sum_r[ax_r] + 21'(smp_r[ax_r])
                   - (full ? 21'(signed'(rdata)) : 21'sd0);

  // Effective divisor after this sample.
  logic [CntW-1:0] fill_eff;
  assign fill_eff = (ok_r && !full) ? fill_r + CntW'(1) : fill_r;

  // Restoring divide step of the magnitude.
  logic [22:0] trem;
  assign trem = {rem_r, quo_r[21]} - 23'(fill_eff);

  logic signed [15:0] q16;
  assign q16 = neg_r ? -quo_r[15:0] : quo_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done <= 1'b0;
      fill_r <= '0;
      slot_r <= '0;
      ax_r <= '0;
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          ax_r <= '0;
          if (start) begin
            ok_r <= ok;
            smp_r[0] <= smp_x;
            smp_r[1] <= smp_y;
            smp_r[2] <= smp_z;
            state_r <= A_RD;
          end
        end
        A_RD: state_r <= A_UPD;
        A_UPD: begin
          if (ok_r) sum_r[ax_r] <= new_sum;
          quo_r <= (ok_r ? new_sum[20] : sum_r[ax_r][20])
                   ? 22'(-(ok_r ? new_sum : sum_r[ax_r]))
                   : 22'(ok_r ? new_sum : sum_r[ax_r]);
          neg_r <= ok_r ? new_sum[20] : sum_r[ax_r][20];
          rem_r <= '0;
          cnt_r <= '0;
          state_r <= A_DIV;
        end
        A_DIV: begin
          if (!trem[22]) rem_r <= trem[21:0];
          else rem_r <= {rem_r[20:0], quo_r[21]};
          quo_r <= {quo_r[20:0], !trem[22]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DivSteps - 1)) state_r <= A_STO;
        end
        A_STO: begin
          if (fill_eff == '0) begin
            if (ax_r == 2'd0) avg_x <= '0;
            if (ax_r == 2'd1) avg_y <= '0;
            if (ax_r == 2'd2) avg_z <= '0;
          end else begin
            if (ax_r == 2'd0) avg_x <= q16;
            if (ax_r == 2'd1) avg_y <= q16;
            if (ax_r == 2'd2) avg_z <= q16;
          end
          if (ax_r == 2'd2) begin
            state_r <= A_FIN;
          end else begin
            ax_r <= ax_r + 2'd1;
            state_r <= A_RD;
          end
        end
        A_FIN: begin
          if (ok_r) begin
            fill_r <= fill_eff;
            slot_r <= (slot_r == SlotW'(Window - 1)) ? '0 : slot_r + SlotW'(1);
          end
          done <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/accel_tilt_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// Accelerometer tilt with a per-axis moving average.
// Input channel: in_valid/in_stall carries one word with three signed axes and
// a sensor flag. A flagged sample enters a window of WINDOW samples kept in a
// RAM with one write port and one registered read port; the running sums are
// updated by read-modify-write.
// Output channel: out_valid/out_stall carries one word per input word: the
// averaged axes, roll and pitch of the held raw sample and of the average.
// From the accepting edge to out_valid, the averager works through the three
// axes in turn, each through its bit-serial divider, then a shared CORDIC
// unit computes four angles in two runs, each angle a 16 step square root and
// 16 CORDIC steps. One word is in flight at a time. The result sits in an
// output register; the next word is accepted while it waits, and is held off
// only until the register is free.
// Reset clears the sums, fill count, slot pointer and held sample; the window
// RAM value is only used once its slot has been written, so it needs no clearing pass.
module accel_tilt_moving_average #(
  parameter int unsigned WINDOW = atma_pkg::WindowDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic        in_sensor_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_valid,
  output logic signed [15:0] out_avg_x,
  output logic signed [15:0] out_avg_y,
  output logic signed [15:0] out_avg_z,
  output logic signed [15:0] out_raw_roll,
  output logic signed [15:0] out_raw_pitch,
  output logic signed [15:0] out_avg_roll,
  output logic signed [15:0] out_avg_pitch
);
  import atma_pkg::*;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_AVG  = 5'b00010,
    T_RAW  = 5'b00100,
    T_FIL  = 5'b01000,
    T_OUT  = 5'b10000
  } top_state_t;

  top_state_t state_r;
  logic ok_r;
  logic signed [15:0] held_r [3];
  logic signed [15:0] rr_r, rp_r;
  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = state_r != T_IDLE;

  logic avg_done, tilt_done, tilt_start;
  logic signed [15:0] ax, ay, az, roll, pitch;

  atma_avg #(.Window(WINDOW)) u_avg (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .ok(in_sensor_ok),
    .smp_x(in_accel_x), .smp_y(in_accel_y), .smp_z(in_accel_z),
    .done(avg_done), .avg_x(ax), .avg_y(ay), .avg_z(az)
  );

  logic sel_avg;
  assign sel_avg = state_r == T_RAW;
  assign tilt_start = (state_r == T_AVG && avg_done) || (state_r == T_RAW && tilt_done);

  atma_tilt u_tilt (
    .clk(clk), .rst_n(rst_n), .start(tilt_start),
    .vec_x(sel_avg ? ax : held_r[0]),
    .vec_y(sel_avg ? ay : held_r[1]),
    .vec_z(sel_avg ? az : held_r[2]),
    .done(tilt_done), .roll(roll), .pitch(pitch)
  );

  // Sequencer: average, raw tilt, filtered tilt, then wait for the output slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) held_r[k] <= '0;
    end else begin
      if (out_acc && state_r != T_OUT) out_valid <= 1'b0;
      unique case (state_r)
        T_IDLE: if (in_acc) begin
          ok_r <= in_sensor_ok;
          if (in_sensor_ok) begin
            held_r[0] <= in_accel_x;
            held_r[1] <= in_accel_y;
            held_r[2] <= in_accel_z;
          end
          state_r <= T_AVG;
        end
        T_AVG: if (avg_done) state_r <= T_RAW;
        T_RAW: if (tilt_done) begin
          rr_r <= roll;
          rp_r <= pitch;
          state_r <= T_FIL;
        end
        T_FIL: if (tilt_done) state_r <= T_OUT;
        T_OUT: if (!out_valid || out_acc) begin
          out_valid <= 1'b1;
          out_result_valid <= ok_r;
          out_avg_x <= ax;
          out_avg_y <= ay;
          out_avg_z <= az;
          out_raw_roll <= rr_r;
          out_raw_pitch <= rp_r;
          out_avg_roll <= roll;
          out_avg_pitch <= pitch;
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // Angles never leave the quarter-turn range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_raw_roll <= AngleHalfPi && out_raw_roll >= -AngleHalfPi))
    else $error("raw roll out of range");
  // A new word is taken only when the sequencer is idle.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == T_AVG)
    else $error("accept did not start averaging");
  // A held result is not replaced while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped");

endmodule
`default_nettype wire
